### rtl/core/sortpq_pkg.sv
// sortpq_pkg: shared types and constants for the sorted priority queue
// holds action, status and sequencer state codes and the stored entry layout
// no dependencies
package sortpq_pkg;

   // default number of queue slots
   localparam int QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int ACTION_W = 2;
   localparam int LEVEL_W  = 3;
   localparam int YEARS_W  = 7;
   localparam int LABEL_W  = 64;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 5;

   // legal ranges of the stored fields
   localparam logic [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(1);
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(4);
   localparam logic [YEARS_W-1:0] YEARS_MIN = YEARS_W'(1);
   localparam logic [YEARS_W-1:0] YEARS_MAX = YEARS_W'(110);

   // requested action
   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_CALL  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // result status
   typedef enum logic [STATUS_W-1:0] {
      STAT_ADDED    = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_CALLED   = 3'd2,
      STAT_EMPTY    = 3'd3,
      STAT_CLEARED  = 3'd4,
      STAT_NO_CLEAR = 3'd5
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_CALL,
      S_DONE
   } state_type;

   // one queue entry as kept in the slot memory
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [YEARS_W-1:0] years;
      logic [LABEL_W-1:0] label_lo;
      logic [LABEL_W-1:0] label_mid;
      logic [LABEL_W-1:0] label_hi;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### rtl/core/sortpq_ram.sv
// sortpq_ram: generic single write port, single read port memory
// read data is registered and appears in the cycle after the address
// no dependencies
module sortpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sorted_priority_queue_top.sv
// sorted_priority_queue_top: bounded priority queue kept in level order in one slot memory.
// add: walks from the tail toward the head, moving each entry of larger level back one slot,
// until an entry of equal or lower level or the head is reached; call and clear need no walk.
// one action at a time; a new action is taken the cycle after a result is loaded.
// reset (synchronous, active high) empties the queue; slot contents are not cleared.
// depends on sortpq_pkg and sortpq_ram
module sorted_priority_queue_top #(
   parameter int QUEUE_DEPTH = sortpq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sortpq_pkg::ACTION_W-1:0]       req_action,
   input  logic [sortpq_pkg::LEVEL_W-1:0]        req_level,
   input  logic [sortpq_pkg::YEARS_W-1:0]        req_years,
   input  logic [sortpq_pkg::LABEL_W-1:0]        req_label_lo,
   input  logic [sortpq_pkg::LABEL_W-1:0]        req_label_mid,
   input  logic [sortpq_pkg::LABEL_W-1:0]        req_label_hi,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sortpq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sortpq_pkg::LEVEL_W-1:0]        rsp_out_level,
   output logic [sortpq_pkg::YEARS_W-1:0]        rsp_out_years,
   output logic [sortpq_pkg::LABEL_W-1:0]        rsp_out_label_lo,
   output logic [sortpq_pkg::LABEL_W-1:0]        rsp_out_label_mid,
   output logic [sortpq_pkg::LABEL_W-1:0]        rsp_out_label_hi,
   output logic [sortpq_pkg::OCC_W-1:0]          rsp_occupancy
);

   import sortpq_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   // sequencer and queue bookkeeping
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     head_ff, head_in;
   logic [PW-1:0]     dst_ff, dst_in;
   logic [CW-1:0]     left_ff, left_in;
   entry_type         item_ff, item_in;
   status_type        status_ff, status_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   entry_type         rsp_ff, rsp_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   // slot memory port
   logic              ram_we;
   logic [PW-1:0]     ram_wr_addr;
   entry_type         ram_wr_data;
   logic [PW-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type         rd_entry;

   // helpers
   logic [SW-1:0]     tail_sum;
   logic [PW-1:0]     tail_w;
   logic [PW-1:0]     src_w;
   logic [PW-1:0]     head_inc;
   logic              out_free;
   logic              is_full;
   logic              is_empty;
   logic              moves_back;
   action_type        act;
   logic [LEVEL_W-1:0] lv_clamp;
   logic [YEARS_W-1:0] yr_clamp;

   assign rd_entry = ram_rd_data;
   assign act      = action_type'(req_action);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);
   assign moves_back = (rd_entry.level > item_ff.level);

   // circular slot arithmetic
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail_w   = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : PW'(tail_sum);
   assign src_w    = (dst_ff == '0) ? LAST_SLOT : dst_ff - PW'(1);
   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + PW'(1);

   // clamp incoming level and age into their legal ranges
   always_comb begin
      if (req_level < LEVEL_MIN) begin
         lv_clamp = LEVEL_MIN;
      end else if (req_level > LEVEL_MAX) begin
         lv_clamp = LEVEL_MAX;
      end else begin
         lv_clamp = req_level;
      end
      if (req_years < YEARS_MIN) begin
         yr_clamp = YEARS_MIN;
      end else if (req_years > YEARS_MAX) begin
         yr_clamp = YEARS_MAX;
      end else begin
         yr_clamp = req_years;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (act)
                  ACT_ADD:   state_in = is_full ? S_DONE : S_INS_RD;
                  ACT_CALL:  state_in = is_empty ? S_DONE : S_CALL;
                  ACT_CLEAR: state_in = S_DONE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_INS_RD:  state_in = (left_ff == '0) ? S_DONE : S_INS_CMP;
         S_INS_CMP: state_in = moves_back ? S_INS_RD : S_DONE;
         S_CALL:    state_in = out_free ? S_IDLE : S_CALL;
         S_DONE:    state_in = out_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // handshake and memory control
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      ram_rd_addr = (state_ff == S_INS_RD) ? src_w : head_ff;
      ram_wr_addr = dst_ff;
      ram_we      = ((state_ff == S_INS_RD) && (left_ff == '0)) || (state_ff == S_INS_CMP);
      ram_wr_data = ((state_ff == S_INS_CMP) && moves_back) ? rd_entry : item_ff;
   end

   // datapath and response next values
   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      dst_in        = dst_ff;
      left_in       = left_ff;
      item_in       = item_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;

      // response slot drains on transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in.level     = lv_clamp;
               item_in.years     = yr_clamp;
               item_in.label_lo  = req_label_lo;
               item_in.label_mid = req_label_mid;
               item_in.label_hi  = req_label_hi;
               dst_in            = tail_w;
               left_in           = count_ff;
               case (act)
                  ACT_ADD: begin
                     status_in = is_full ? STAT_FULL : STAT_ADDED;
                  end
                  ACT_CALL: begin
                     status_in = STAT_EMPTY;
                  end
                  ACT_CLEAR: begin
                     status_in = is_empty ? STAT_NO_CLEAR : STAT_CLEARED;
                     count_in  = '0;
                     head_in   = '0;
                  end
                  default: begin
                     status_in = status_ff;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            // nothing left to walk past: the new entry lands here
            if (left_ff == '0) begin
               count_in = count_ff + CW'(1);
            end
         end
         S_INS_CMP: begin
            // larger level moves back one slot, else the new entry goes in
            if (moves_back) begin
               dst_in  = src_w;
               left_in = left_ff - CW'(1);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         S_CALL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = rd_entry;
               rsp_status_in = STAT_CALLED;
               rsp_occ_in    = OCC_W'(count_ff - CW'(1));
               count_in      = count_ff - CW'(1);
               head_in       = head_inc;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_status_in = status_ff;
               rsp_occ_in    = OCC_W'(count_ff);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      item_ff       <= item_in;
      status_ff     <= status_in;
      rsp_ff        <= rsp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // slot memory
   sortpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_level     = rsp_ff.level;
   assign rsp_out_years     = rsp_ff.years;
   assign rsp_out_label_lo  = rsp_ff.label_lo;
   assign rsp_out_label_mid = rsp_ff.label_mid;
   assign rsp_out_label_hi  = rsp_ff.label_hi;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule
